/* rtl/sci_pkg.sv */
// Shared types, widths, codes and fixed-point constants for the soft CKY inside chart.
// No dependencies; every other file except sci_ram refers to this package by scoped names.
package sci_pkg;

  localparam int MAX_LEN_DEFAULT = 32;

  localparam int ACT_W      = 3;
  localparam int POS_W      = 5;
  localparam int SCORE_W    = 24;
  localparam int TEMP_W     = 16;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int TERM_W    = SCORE_W + 2;   // sum of three scores
  localparam int MUL_W     = 32;
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 26;
  localparam int DIV_CNT_W = 6;
  localparam int L_W       = 28;            // log of the exp sum, Q.24

  localparam logic [24:0] Q24_ONE         = 25'h100_0000;
  localparam logic [22:0] EXP_NEG_ONE_Q24 = 23'd6171993;
  localparam logic [23:0] LN2_Q24         = 24'd11629080;
  localparam logic [18:0] EXP_CUTOFF_Q12  = 19'd360448;

  localparam logic [LEN_W-1:0]  LEN_RESET   = 6'd1;
  localparam logic [TEMP_W-1:0] TEMP_RESET  = 16'd4096;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7F_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = -24'sh80_0000;

  typedef enum logic [ACT_W-1:0] {
    ACT_LEAF    = 3'd0,
    ACT_MERGE   = 3'd1,
    ACT_TEMP    = 3'd2,
    ACT_COMPUTE = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  localparam logic [CFG_IDX_W-1:0] REG_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TSCALAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TVALUE  = 2'd2;

  localparam logic RK_ROOT = 1'b0;
  localparam logic RK_READ = 1'b1;

  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  typedef struct packed {
    logic                      neg_inf;
    logic signed [SCORE_W-1:0] score;
  } cell_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_RD_CAP, S_OUT,
    S_SPAN, S_T_CAP, S_RD_L, S_RD_R, S_TERM, S_NEXT,
    S_Q_WAIT, S_E_MUL, S_E_DIV, S_E_WAIT, S_E_CLAMP,
    S_A_CHK, S_A_MUL, S_A_UPD,
    S_LN_INIT, S_LN_NORM, S_Z_DIV, S_Z_WAIT, S_Z2_MUL, S_Z2_UPD,
    S_P_DIV, S_P_WAIT, S_P_MUL, S_P_UPD, S_L, S_T_MUL,
    S_FIN, S_WR_NI, S_SPAN_NEXT, S_ROOT, S_ROOT_CAP
  } state_t;

endpackage

/* rtl/sci_if.sv */
// Valid/ready channel interfaces for input items and result words.
// Depends on sci_pkg for field widths.
interface sci_req_if;
  logic                              valid;
  logic                              ready;
  logic [sci_pkg::ACT_W-1:0]         action;
  logic [sci_pkg::POS_W-1:0]         pos_i;
  logic [sci_pkg::POS_W-1:0]         pos_k;
  logic [sci_pkg::POS_W-1:0]         pos_j;
  logic signed [sci_pkg::SCORE_W-1:0] score_value;
  logic                              score_is_neg_inf;
  logic [sci_pkg::TEMP_W-1:0]        span_temperature;

  modport source (output valid, action, pos_i, pos_k, pos_j, score_value,
                  score_is_neg_inf, span_temperature, input ready);
  modport sink (input valid, action, pos_i, pos_k, pos_j, score_value,
                score_is_neg_inf, span_temperature, output ready);
endinterface

interface sci_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic signed [sci_pkg::SCORE_W-1:0] span_score;
  logic                              span_neg_inf;
  logic                              status;

  modport source (output valid, result_kind, span_score, span_neg_inf, status,
                  input ready);
  modport sink (input valid, result_kind, span_score, span_neg_inf, status,
                output ready);
endinterface

/* rtl/sci_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sci_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sci_div.sv */
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on sci_pkg for widths and the status struct.
module sci_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sci_pkg::DIV_NUM_W-1:0]     dividend,
  input  logic [sci_pkg::DIV_DEN_W-1:0]     divisor,
  output logic [sci_pkg::DIV_NUM_W-1:0]     quotient,
  output sci_pkg::div_stat_t                stat
);

  localparam int NW = sci_pkg::DIV_NUM_W;
  localparam int DW = sci_pkg::DIV_DEN_W;

  logic [DW:0]                       rem;
  logic [DW-1:0]                     dvs;
  logic [sci_pkg::DIV_CNT_W-1:0]     cnt;
  logic [DW:0]                       rem_sh;
  logic                              fits;

  // quotient bits shift in from the right as the dividend shifts out on the left
  assign rem_sh = {rem[DW-1:0], quotient[NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= sci_pkg::DIV_CNT_W'(NW);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == sci_pkg::DIV_CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (stat.busy) begin
      quotient <= {quotient[NW-2:0], fits};
      rem      <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
    end
  end

endmodule

/* rtl/soft_cky_inside_chart.sv */
// Soft CKY inside chart: chart, merge and temperature RAMs with one sequencer, one
// registered multiplier and the shared serial divider. Depends on sci_pkg, sci_if,
// sci_ram and sci_div.
//
// Leaf, merge and temperature loads are written as they are accepted, back to back.
// A valid read captures the cell in S_RD_CAP, then waits in S_OUT for the result
// register. A compute walks every span of length 2..n, shortest first: one pass over
// its splits for the maximum and, if any term is finite, a second pass to revisit
// them, with the Taylor terms and up to one multiply by exp(-1) per whole unit of the
// scaled exponent (up to 88) for each finite term, and a logarithm per span. The serial
// divider serves the temperature division, the Taylor terms and the log series. The
// input is held off for the whole compute; no memory clearing is needed after reset.
module soft_cky_inside_chart #(
  parameter int MAX_LEN = sci_pkg::MAX_LEN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  sci_req_if.sink                          req,
  sci_rsp_if.source                        rsp,
  input  logic                             cfg_we,
  input  logic [sci_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sci_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IW  = $clog2(MAX_LEN);
  localparam int NW  = $clog2(MAX_LEN + 1);
  localparam int CD  = MAX_LEN * MAX_LEN;
  localparam int MD  = CD * MAX_LEN;
  localparam int CAW = $clog2(CD);
  localparam int MAW = $clog2(MD);
  localparam int SEW = 25 + IW;
  localparam int EW  = $clog2(IW + 1);
  localparam int CW  = (NW > sci_pkg::POS_W) ? NW : sci_pkg::POS_W;
  localparam int CELL_W = sci_pkg::SCORE_W + 1;

  // configuration
  logic [sci_pkg::LEN_W-1:0]  sent_len;
  logic                       temp_scalar;
  logic [sci_pkg::TEMP_W-1:0] scalar_temp;
  logic [NW-1:0]              n_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_len    <= sci_pkg::LEN_RESET;
      temp_scalar <= 1'b1;
      scalar_temp <= sci_pkg::TEMP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sci_pkg::REG_LEN:     sent_len    <= cfg_data[sci_pkg::LEN_W-1:0];
        sci_pkg::REG_TSCALAR: temp_scalar <= cfg_data[0];
        sci_pkg::REG_TVALUE:  scalar_temp <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sent_len == '0) begin
      n_act = NW'(1);
    end else if (32'(sent_len) > MAX_LEN) begin
      n_act = NW'(MAX_LEN);
    end else begin
      n_act = NW'(sent_len);
    end
  end

  function automatic logic [CAW-1:0] chart_addr(input logic [IW-1:0] i,
                                                input logic [IW-1:0] j);
    chart_addr = CAW'(32'(i) * MAX_LEN + 32'(j));
  endfunction

  function automatic logic [MAW-1:0] merge_addr(input logic [IW-1:0] i,
                                                input logic [IW-1:0] k,
                                                input logic [IW-1:0] j);
    merge_addr = MAW'((32'(i) * MAX_LEN + 32'(k)) * MAX_LEN + 32'(j));
  endfunction

  // memories
  logic                       chart_we, merge_we, temp_we;
  logic [CAW-1:0]             chart_waddr, chart_raddr, temp_waddr, temp_raddr;
  logic [MAW-1:0]             merge_waddr, merge_raddr;
  sci_pkg::cell_t             chart_wdata, chart_q, merge_wdata, merge_q;
  logic [sci_pkg::TEMP_W-1:0] temp_wdata, temp_q;

  sci_ram #(.W(CELL_W), .D(CD)) u_chart (
    .clk(clk), .we(chart_we), .waddr(chart_waddr), .wdata(chart_wdata),
    .raddr(chart_raddr), .rdata(chart_q)
  );

  sci_ram #(.W(CELL_W), .D(MD)) u_merge (
    .clk(clk), .we(merge_we), .waddr(merge_waddr), .wdata(merge_wdata),
    .raddr(merge_raddr), .rdata(merge_q)
  );

  sci_ram #(.W(sci_pkg::TEMP_W), .D(CD)) u_temp (
    .clk(clk), .we(temp_we), .waddr(temp_waddr), .wdata(temp_wdata),
    .raddr(temp_raddr), .rdata(temp_q)
  );

  // shared divider and multiplier
  logic                             div_start;
  logic [sci_pkg::DIV_NUM_W-1:0]    div_num, div_quot;
  logic [sci_pkg::DIV_DEN_W-1:0]    div_den;
  sci_pkg::div_stat_t               div_stat;

  sci_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(div_den),
    .quotient(div_quot), .stat(div_stat)
  );

  logic [sci_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [2*sci_pkg::MUL_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer state and datapath registers
  sci_pkg::state_t state, state_next;

  logic [NW-1:0]                     len;
  logic [IW-1:0]                     a_idx, i_idx, j_idx, k_idx;
  logic                              pass2, any;
  logic [sci_pkg::TEMP_W-1:0]        temp_t;
  sci_pkg::cell_t                    l_cell, ms_cell;
  logic signed [sci_pkg::TERM_W-1:0] m_max;
  logic [11:0]                       f;
  logic [6:0]                        a_cnt;
  logic [24:0]                       term, v;
  logic signed [26:0]                sum_t;
  logic [3:0]                        nn, kk;
  logic [SEW-1:0]                    sum_e, r;
  logic [EW-1:0]                     e_cnt;
  logic [23:0]                       z, z2, p;
  logic [25:0]                       acc;
  logic [sci_pkg::L_W-1:0]           l_val;

  logic                              res_kind, res_ni, res_status;
  logic signed [sci_pkg::SCORE_W-1:0] res_score;
  logic                              out_valid;

  // combinational helpers
  logic                              in_acc;
  logic                              pi_ok, pk_ok, pj_ok;
  logic [IW-1:0]                     pi, pk, pj, span_j, root_j;
  logic [NW:0]                       span_j_full;
  logic signed [sci_pkg::TERM_W-1:0] t_sum;
  logic                              t_ok;
  logic signed [26:0]                d_full;
  logic                              split_end, span_row_end, q_cut;
  logic [24:0]                       r_low;
  logic [63:0]                       prod_rnd;
  logic signed [27:0]                fin_sum;
  logic signed [sci_pkg::SCORE_W-1:0] fin_sat;
  sci_pkg::cell_t                    load_cell;

  assign in_acc = req.valid && req.ready;
  assign pi_ok  = CW'(req.pos_i) < CW'(n_act);
  assign pk_ok  = CW'(req.pos_k) < CW'(n_act);
  assign pj_ok  = CW'(req.pos_j) < CW'(n_act);
  assign pi     = IW'(req.pos_i);
  assign pk     = IW'(req.pos_k);
  assign pj     = IW'(req.pos_j);

  assign load_cell.neg_inf = req.score_is_neg_inf;
  assign load_cell.score   = req.score_is_neg_inf ? '0 : req.score_value;

  assign span_j_full  = (NW+1)'(a_idx) + (NW+1)'(len) - (NW+1)'(1);
  assign span_j       = IW'(span_j_full);
  assign root_j       = IW'(n_act - NW'(1));
  assign span_row_end = j_idx == root_j;

  assign t_sum = sci_pkg::TERM_W'(l_cell.score) + sci_pkg::TERM_W'(chart_q.score)
               + sci_pkg::TERM_W'(ms_cell.score);
  assign t_ok  = !(l_cell.neg_inf || chart_q.neg_inf || ms_cell.neg_inf);
  assign d_full = 27'(m_max) - 27'(t_sum);

  assign split_end = IW'(k_idx + IW'(1)) == j_idx;
  assign q_cut     = div_quot > sci_pkg::DIV_NUM_W'(sci_pkg::EXP_CUTOFF_Q12);
  assign r_low     = r[24:0];

  assign prod_rnd = prod + 64'h80_0000;
  assign fin_sum  = 28'(m_max) + $signed({5'b0, prod_rnd[46:24]});

  always_comb begin
    if (fin_sum > 28'(sci_pkg::SCORE_MAX)) begin
      fin_sat = sci_pkg::SCORE_MAX;
    end else if (fin_sum < 28'(sci_pkg::SCORE_MIN)) begin
      fin_sat = sci_pkg::SCORE_MIN;
    end else begin
      fin_sat = fin_sum[sci_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sci_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sci_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (req.action)
            sci_pkg::ACT_COMPUTE:
              state_next = (n_act == NW'(1)) ? sci_pkg::S_ROOT : sci_pkg::S_SPAN;
            sci_pkg::ACT_READ:
              state_next = (pi_ok && pj_ok && req.pos_i <= req.pos_j) ?
                           sci_pkg::S_RD_CAP : sci_pkg::S_OUT;
            default: state_next = sci_pkg::S_IDLE;
          endcase
        end
      end
      sci_pkg::S_RD_CAP:   state_next = sci_pkg::S_OUT;
      sci_pkg::S_OUT:      if (!out_valid || rsp.ready) state_next = sci_pkg::S_IDLE;
      sci_pkg::S_SPAN:     state_next = sci_pkg::S_T_CAP;
      sci_pkg::S_T_CAP:    state_next = sci_pkg::S_RD_L;
      sci_pkg::S_RD_L:     state_next = sci_pkg::S_RD_R;
      sci_pkg::S_RD_R:     state_next = sci_pkg::S_TERM;
      sci_pkg::S_TERM:
        state_next = (pass2 && t_ok) ? sci_pkg::S_Q_WAIT : sci_pkg::S_NEXT;
      sci_pkg::S_NEXT: begin
        if (!split_end) begin
          state_next = sci_pkg::S_RD_L;
        end else if (pass2) begin
          state_next = sci_pkg::S_LN_INIT;
        end else begin
          state_next = any ? sci_pkg::S_RD_L : sci_pkg::S_WR_NI;
        end
      end
      sci_pkg::S_Q_WAIT:
        if (div_stat.done) state_next = q_cut ? sci_pkg::S_NEXT : sci_pkg::S_E_MUL;
      sci_pkg::S_E_MUL:    state_next = sci_pkg::S_E_DIV;
      sci_pkg::S_E_DIV:    state_next = sci_pkg::S_E_WAIT;
      sci_pkg::S_E_WAIT:
        if (div_stat.done)
          state_next = (nn == 4'd12) ? sci_pkg::S_E_CLAMP : sci_pkg::S_E_MUL;
      sci_pkg::S_E_CLAMP:  state_next = sci_pkg::S_A_CHK;
      sci_pkg::S_A_CHK:
        state_next = (a_cnt == '0 || v == '0) ? sci_pkg::S_NEXT : sci_pkg::S_A_MUL;
      sci_pkg::S_A_MUL:    state_next = sci_pkg::S_A_UPD;
      sci_pkg::S_A_UPD:    state_next = sci_pkg::S_A_CHK;
      sci_pkg::S_LN_INIT:  state_next = sci_pkg::S_LN_NORM;
      sci_pkg::S_LN_NORM:
        if (r[SEW-1:25] == '0) state_next = sci_pkg::S_Z_DIV;
      sci_pkg::S_Z_DIV:    state_next = sci_pkg::S_Z_WAIT;
      sci_pkg::S_Z_WAIT:   if (div_stat.done) state_next = sci_pkg::S_Z2_MUL;
      sci_pkg::S_Z2_MUL:   state_next = sci_pkg::S_Z2_UPD;
      sci_pkg::S_Z2_UPD:   state_next = sci_pkg::S_P_DIV;
      sci_pkg::S_P_DIV:    state_next = sci_pkg::S_P_WAIT;
      sci_pkg::S_P_WAIT:
        if (div_stat.done)
          state_next = (kk == 4'd15) ? sci_pkg::S_L : sci_pkg::S_P_MUL;
      sci_pkg::S_P_MUL:    state_next = sci_pkg::S_P_UPD;
      sci_pkg::S_P_UPD:    state_next = sci_pkg::S_P_DIV;
      sci_pkg::S_L:        state_next = sci_pkg::S_T_MUL;
      sci_pkg::S_T_MUL:    state_next = sci_pkg::S_FIN;
      sci_pkg::S_FIN:      state_next = sci_pkg::S_SPAN_NEXT;
      sci_pkg::S_WR_NI:    state_next = sci_pkg::S_SPAN_NEXT;
      sci_pkg::S_SPAN_NEXT:
        state_next = (span_row_end && len == n_act) ? sci_pkg::S_ROOT : sci_pkg::S_SPAN;
      sci_pkg::S_ROOT:     state_next = sci_pkg::S_ROOT_CAP;
      sci_pkg::S_ROOT_CAP: state_next = sci_pkg::S_OUT;
      default:             state_next = sci_pkg::S_IDLE;
    endcase
  end

  // outputs: memory ports, multiplier operands, divider launch
  always_comb begin
    req.ready   = state == sci_pkg::S_IDLE;
    chart_we    = 1'b0;
    chart_waddr = chart_addr(i_idx, j_idx);
    chart_wdata = load_cell;
    chart_raddr = chart_addr(i_idx, k_idx);
    merge_we    = 1'b0;
    merge_waddr = merge_addr(pi, pk, pj);
    merge_wdata = load_cell;
    merge_raddr = merge_addr(i_idx, k_idx, j_idx);
    temp_we     = 1'b0;
    temp_waddr  = chart_addr(pi, pj);
    temp_wdata  = req.span_temperature;
    temp_raddr  = chart_addr(a_idx, span_j);
    mul_a       = sci_pkg::MUL_W'(term);
    mul_b       = sci_pkg::MUL_W'(f);
    div_start   = 1'b0;
    div_num     = sci_pkg::DIV_NUM_W'({d_full[25:0], 12'b0});
    div_den     = sci_pkg::DIV_DEN_W'(temp_t);
    unique case (state)
      sci_pkg::S_IDLE: begin
        chart_raddr = chart_addr(pi, pj);
        if (in_acc) begin
          unique case (req.action)
            sci_pkg::ACT_LEAF: begin
              chart_we    = pi_ok;
              chart_waddr = chart_addr(pi, pi);
            end
            sci_pkg::ACT_MERGE: merge_we = pi_ok && pk_ok && pj_ok;
            sci_pkg::ACT_TEMP:  temp_we  = pi_ok && pj_ok;
            default: ;
          endcase
        end
      end
      sci_pkg::S_RD_R: chart_raddr = chart_addr(IW'(k_idx + IW'(1)), j_idx);
      sci_pkg::S_TERM: div_start = pass2 && t_ok;
      sci_pkg::S_E_DIV: begin
        div_start = 1'b1;
        div_num   = sci_pkg::DIV_NUM_W'(prod[63:12]);
        div_den   = sci_pkg::DIV_DEN_W'(nn);
      end
      sci_pkg::S_A_MUL: begin
        mul_a = sci_pkg::MUL_W'(v);
        mul_b = sci_pkg::MUL_W'(sci_pkg::EXP_NEG_ONE_Q24);
      end
      sci_pkg::S_Z_DIV: begin
        div_start = 1'b1;
        div_num   = sci_pkg::DIV_NUM_W'({24'(r_low - sci_pkg::Q24_ONE), 24'b0});
        div_den   = sci_pkg::DIV_DEN_W'(r_low) + sci_pkg::DIV_DEN_W'(sci_pkg::Q24_ONE);
      end
      sci_pkg::S_Z2_MUL: begin
        mul_a = sci_pkg::MUL_W'(z);
        mul_b = sci_pkg::MUL_W'(z);
      end
      sci_pkg::S_P_DIV: begin
        div_start = 1'b1;
        div_num   = sci_pkg::DIV_NUM_W'(p);
        div_den   = sci_pkg::DIV_DEN_W'(kk);
      end
      sci_pkg::S_P_MUL: begin
        mul_a = sci_pkg::MUL_W'(p);
        mul_b = sci_pkg::MUL_W'(z2);
      end
      sci_pkg::S_T_MUL: begin
        mul_a = sci_pkg::MUL_W'(temp_t);
        mul_b = sci_pkg::MUL_W'(l_val);
      end
      sci_pkg::S_FIN: begin
        chart_we          = 1'b1;
        chart_wdata.neg_inf = 1'b0;
        chart_wdata.score   = fin_sat;
      end
      sci_pkg::S_WR_NI: begin
        chart_we          = 1'b1;
        chart_wdata.neg_inf = 1'b1;
        chart_wdata.score   = '0;
      end
      sci_pkg::S_ROOT: chart_raddr = chart_addr('0, root_j);
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      sci_pkg::S_IDLE: begin
        if (in_acc && req.action == sci_pkg::ACT_COMPUTE) begin
          len   <= NW'(2);
          a_idx <= '0;
        end
        if (in_acc && req.action == sci_pkg::ACT_READ) begin
          res_kind   <= sci_pkg::RK_READ;
          res_score  <= '0;
          res_ni     <= pi_ok && pj_ok;
          res_status <= (pi_ok && pj_ok) ? sci_pkg::STAT_OK : sci_pkg::STAT_RANGE;
        end
      end
      sci_pkg::S_RD_CAP, sci_pkg::S_ROOT_CAP: begin
        res_kind   <= (state == sci_pkg::S_ROOT_CAP) ? sci_pkg::RK_ROOT : sci_pkg::RK_READ;
        res_score  <= chart_q.score;
        res_ni     <= chart_q.neg_inf;
        res_status <= sci_pkg::STAT_OK;
      end
      sci_pkg::S_SPAN: begin
        i_idx <= a_idx;
        j_idx <= span_j;
        k_idx <= a_idx;
        pass2 <= 1'b0;
        any   <= 1'b0;
      end
      sci_pkg::S_T_CAP: begin
        temp_t <= temp_scalar ? scalar_temp : temp_q;
        if ((temp_scalar ? scalar_temp : temp_q) == '0) temp_t <= sci_pkg::TEMP_W'(1);
      end
      sci_pkg::S_RD_R: begin
        l_cell  <= chart_q;
        ms_cell <= merge_q;
      end
      sci_pkg::S_TERM: begin
        if (!pass2 && t_ok && (!any || t_sum > m_max)) begin
          m_max <= t_sum;
          any   <= 1'b1;
        end
      end
      sci_pkg::S_NEXT: begin
        if (!split_end) begin
          k_idx <= IW'(k_idx + IW'(1));
        end else if (!pass2) begin
          pass2 <= 1'b1;
          k_idx <= i_idx;
          sum_e <= '0;
        end
      end
      sci_pkg::S_Q_WAIT: begin
        f     <= div_quot[11:0];
        a_cnt <= div_quot[18:12];
        term  <= sci_pkg::Q24_ONE;
        sum_t <= $signed({2'b00, sci_pkg::Q24_ONE});
        nn    <= 4'd1;
      end
      sci_pkg::S_E_WAIT: begin
        if (div_stat.done) begin
          term  <= div_quot[24:0];
          sum_t <= nn[0] ? sum_t - $signed({2'b00, div_quot[24:0]})
                         : sum_t + $signed({2'b00, div_quot[24:0]});
          nn    <= nn + 4'd1;
        end
      end
      sci_pkg::S_E_CLAMP: begin
        if (sum_t < 0) begin
          v <= '0;
        end else if (sum_t > $signed({2'b00, sci_pkg::Q24_ONE})) begin
          v <= sci_pkg::Q24_ONE;
        end else begin
          v <= sum_t[24:0];
        end
      end
      sci_pkg::S_A_CHK: begin
        if (a_cnt == '0 || v == '0) sum_e <= sum_e + SEW'(v);
      end
      sci_pkg::S_A_UPD: begin
        v     <= prod[48:24];
        a_cnt <= a_cnt - 7'd1;
      end
      sci_pkg::S_LN_INIT: begin
        r     <= (sum_e < SEW'(sci_pkg::Q24_ONE)) ? SEW'(sci_pkg::Q24_ONE) : sum_e;
        e_cnt <= '0;
      end
      sci_pkg::S_LN_NORM: begin
        if (r[SEW-1:25] != '0) begin
          r     <= r >> 1;
          e_cnt <= e_cnt + EW'(1);
        end
      end
      sci_pkg::S_Z_WAIT: begin
        z <= div_quot[23:0];
        p <= div_quot[23:0];
      end
      sci_pkg::S_Z2_UPD: begin
        z2  <= prod[47:24];
        acc <= '0;
        kk  <= 4'd1;
      end
      sci_pkg::S_P_WAIT: begin
        if (div_stat.done) acc <= acc + 26'(div_quot[23:0]);
      end
      sci_pkg::S_P_UPD: begin
        p  <= prod[47:24];
        kk <= kk + 4'd2;
      end
      sci_pkg::S_L: begin
        l_val <= sci_pkg::L_W'(32'(e_cnt) * 32'(sci_pkg::LN2_Q24))
               + sci_pkg::L_W'({acc, 1'b0});
      end
      sci_pkg::S_SPAN_NEXT: begin
        if (span_row_end) begin
          len   <= NW'(len + NW'(1));
          a_idx <= '0;
        end else begin
          a_idx <= IW'(a_idx + IW'(1));
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sci_pkg::S_OUT && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sci_pkg::S_OUT && (!out_valid || rsp.ready)) begin
      rsp.result_kind  <= res_kind;
      rsp.span_score   <= res_ni ? '0 : res_score;
      rsp.span_neg_inf <= res_ni;
      rsp.status       <= res_status;
    end
  end

  assign rsp.valid = out_valid;

  // checks
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");

  a_idle_div_free: assert property (@(posedge clk) disable iff (rst)
    state == sci_pkg::S_IDLE |-> !div_stat.busy)
    else $error("divider still running with sequencer idle");

  a_span_upper: assert property (@(posedge clk) disable iff (rst)
    (state == sci_pkg::S_FIN || state == sci_pkg::S_WR_NI) |-> i_idx < j_idx)
    else $error("span write on or below the diagonal");

  a_word_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == sci_pkg::S_OUT)
    else $error("result word raised outside the output state");

endmodule
